### design/swir_pkg.sv
// Shared types, codes and defaults for the stack with indexed read and search.
package swir_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_WORD_WIDTH = 64;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 64;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int FOUND_W  = 6;
   localparam int COUNT_W  = 7;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  data_out;
      logic [FOUND_W-1:0]  found_index;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic                is_full;
   } swir_result_type;

endpackage

### design/swir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swir_ram
   import swir_pkg::*;
#(
   parameter int WIDTH = DEF_WORD_WIDTH,
   parameter int DEPTH = DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/swir_seq.sv
// Sequencer: fill count, request decode and the shared compare walk over the RAM.
module swir_seq
   import swir_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic [VALUE_W-1:0]          req_value,
   input  logic [INDEX_W-1:0]          req_index,
   output logic                        ram_we,
   output logic [$clog2(CAPACITY)-1:0] ram_waddr,
   output logic [WORD_WIDTH-1:0]       ram_wdata,
   output logic [$clog2(CAPACITY)-1:0] ram_raddr,
   input  logic [WORD_WIDTH-1:0]       ram_rdata,
   output logic                        res_valid,
   output swir_result_type             res
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int IXW = CW + INDEX_W;
   localparam int CXW = CW + COUNT_W;
   localparam int FXW = AW + FOUND_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [WORD_WIDTH-1:0] key_ff, key_in;

   logic [CW-1:0]  count_m1;
   logic           stk_empty;
   logic           stk_full;
   logic           scan_last;
   logic [IXW-1:0] idx_wide;
   logic [IXW-1:0] cnt_cmp;
   logic [CXW-1:0] cnt_wide;
   logic [FXW-1:0] ptr_wide;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  data;
   logic [FOUND_W-1:0]  found;

   assign count_m1  = count_ff - CW'(1);
   assign stk_empty = (count_ff == '0);
   assign stk_full  = (count_ff == CW'(CAPACITY));
   assign scan_last = ((CW'(ptr_ff) + CW'(1)) == count_ff);
   assign idx_wide  = IXW'(req_index);
   assign cnt_cmp   = IXW'(count_ff);
   assign ptr_wide  = FXW'(ptr_ff);
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      key_in    = key_ff;
      ram_we    = 1'b0;
      ram_waddr = count_ff[AW-1:0];
      ram_wdata = req_value[WORD_WIDTH-1:0];
      ram_raddr = ptr_ff + AW'(1);
      res_valid = 1'b0;
      status    = ST_OK;
      data      = '0;
      found     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in = req_value[WORD_WIDTH-1:0];
               case (req_mode)
                  MODE_PUSH: begin
                     res_valid = 1'b1;
                     if (stk_full) begin
                        status = ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_POP: begin
                     if (stk_empty) begin
                        res_valid = 1'b1;
                        status    = ST_EMPTY;
                     end else begin
                        count_in  = count_m1;
                        ram_raddr = count_m1[AW-1:0];
                        state_in  = S_READ;
                     end
                  end
                  MODE_READ: begin
                     if (stk_empty) begin
                        res_valid = 1'b1;
                        status    = ST_EMPTY;
                     end else if (idx_wide >= cnt_cmp) begin
                        res_valid = 1'b1;
                        status    = ST_RANGE;
                     end else begin
                        ram_raddr = idx_wide[AW-1:0];
                        state_in  = S_READ;
                     end
                  end
                  MODE_SEARCH: begin
                     if (stk_empty) begin
                        res_valid = 1'b1;
                        status    = ST_NOTFOUND;
                     end else begin
                        ram_raddr = '0;
                        ptr_in    = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            res_valid = 1'b1;
            data      = VALUE_W'(ram_rdata);
            state_in  = S_IDLE;
         end
         S_SCAN: begin
            if (ram_rdata == key_ff) begin
               res_valid = 1'b1;
               found     = ptr_wide[FOUND_W-1:0];
               state_in  = S_IDLE;
            end else if (scan_last) begin
               res_valid = 1'b1;
               status    = ST_NOTFOUND;
               state_in  = S_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cnt_wide = CXW'(count_in);

   always_comb begin
      res.status      = status;
      res.data_out    = data;
      res.found_index = found;
      res.count       = cnt_wide[COUNT_W-1:0];
      res.is_empty    = (count_in == '0);
      res.is_full     = (count_in == CW'(CAPACITY));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      key_ff <= key_in;
   end

endmodule

### design/stack_with_index_read_and_search.sv
// Top level: stack with indexed read and linear search, with registered response.
// Push and every error: rsp_strobe rises in the cycle after the request, busy never rises.
// Pop and read: S_READ takes the RAM word, then the response register; busy while in S_READ.
// Search: busy in S_SCAN until the lowest hit or the top entry; then the response register.
// Search walks the single RAM read port with one comparator, one entry a cycle.
// Synchronous reset empties the stack; RAM contents are not cleared.
module stack_with_index_read_and_search
   import swir_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [INDEX_W-1:0]  req_index,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_data_out,
   output logic [FOUND_W-1:0]  rsp_found_index,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_is_empty,
   output logic                rsp_is_full
);

   localparam int AW = $clog2(CAPACITY);

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [WORD_WIDTH-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [WORD_WIDTH-1:0] ram_rdata;
   logic                  res_valid;
   swir_result_type       res;
   logic                  strobe_ff;
   swir_result_type       rsp_ff;

   swir_seq #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_mode  (req_mode),
      .req_value (req_value),
      .req_index (req_index),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res       (res)
   );

   swir_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_data_out    = rsp_ff.data_out;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_count       = rsp_ff.count;
   assign rsp_is_empty    = rsp_ff.is_empty;
   assign rsp_is_full     = rsp_ff.is_full;

   a_push_one_cycle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_PUSH |=> rsp_strobe)
      else $error("push request without response in next cycle");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_FULL |-> rsp_is_full)
      else $error("dropped push reported while not full");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_count == '0)
      else $error("empty status with stored words");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_is_empty && rsp_is_full))
      else $error("empty and full flagged together");

endmodule

### tb/testbench.sv
// Testbench for the stack with indexed read and search: directed and random requests.
`timescale 1ns / 100ps

module testbench;
   import swir_pkg::*;

   localparam int STACK_DEPTH  = DEF_CAPACITY;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = STACK_DEPTH + 16;
   localparam int PRINT_LIMIT  = 50;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [MODE_W-1:0]   req_mode;
   logic [VALUE_W-1:0]  req_value;
   logic [INDEX_W-1:0]  req_index;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_data_out;
   logic [FOUND_W-1:0]  rsp_found_index;
   logic [COUNT_W-1:0]  rsp_count;
   logic                rsp_is_empty;
   logic                rsp_is_full;

   logic [VALUE_W-1:0] stack_words [STACK_DEPTH];
   int                 stack_fill;
   logic [VALUE_W-1:0] word_pool [8];
   swir_result_type    pending_results [$];
   int                 error_count;
   int                 cycle_count;
   int                 burst_left;

   stack_with_index_read_and_search dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** stack_with_index_read_and_search: FAILED **");
         $finish;
      end
   end

   function automatic swir_result_type predict_stack_result(input logic [MODE_W-1:0] mode,
                                                            input logic [VALUE_W-1:0] value,
                                                            input logic [INDEX_W-1:0] index);
      swir_result_type r;
      bit              hit;
      r   = '0;
      hit = 1'b0;
      case (mode)
         MODE_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               stack_words[stack_fill] = value;
               stack_fill++;
            end
         end
         MODE_POP: begin
            if (stack_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               stack_fill--;
               r.data_out = stack_words[stack_fill];
            end
         end
         MODE_READ: begin
            if (stack_fill == 0) begin
               r.status = ST_EMPTY;
            end else if (int'(index) >= stack_fill) begin
               r.status = ST_RANGE;
            end else begin
               r.data_out = stack_words[index];
            end
         end
         default: begin
            for (int i = 0; i < stack_fill && !hit; i++) begin
               if (stack_words[i] == value) begin
                  hit           = 1'b1;
                  r.found_index = FOUND_W'(i);
               end
            end
            if (!hit) r.status = ST_NOTFOUND;
         end
      endcase
      r.count    = COUNT_W'(stack_fill);
      r.is_empty = (stack_fill == 0);
      r.is_full  = (stack_fill == STACK_DEPTH);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      swir_result_type seen;
      swir_result_type want;
      if (!reset && rsp_strobe) begin
         seen = '{rsp_status, rsp_data_out, rsp_found_index, rsp_count,
                  rsp_is_empty, rsp_is_full};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", seen.data_out, '0);
         end else begin
            want = pending_results.pop_front();
            if (seen.status !== want.status)
               report_mismatch("status", VALUE_W'(seen.status), VALUE_W'(want.status));
            if (seen.data_out !== want.data_out)
               report_mismatch("data_out", seen.data_out, want.data_out);
            if (seen.found_index !== want.found_index)
               report_mismatch("found_index", VALUE_W'(seen.found_index),
                               VALUE_W'(want.found_index));
            if (seen.count !== want.count)
               report_mismatch("count", VALUE_W'(seen.count), VALUE_W'(want.count));
            if (seen.is_empty !== want.is_empty)
               report_mismatch("is_empty", VALUE_W'(seen.is_empty), VALUE_W'(want.is_empty));
            if (seen.is_full !== want.is_full)
               report_mismatch("is_full", VALUE_W'(seen.is_full), VALUE_W'(want.is_full));
         end
      end
   end

   // Leaves start high on return; a gap before the next request or wait_for_results lowers it.
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] index);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
         gap        = 0;
         burst_left = $urandom_range(10, 40);
      end else begin
         gap = $urandom_range(0, 14);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_stack_result(mode, value, index));
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return word_pool[$urandom_range(0, 7)];
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic run_traffic(input int items, input int w_push, input int w_pop,
                              input int w_read);
      int                 pick;
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      for (int n = 0; n < items; n++) begin
         pick  = $urandom_range(0, 99);
         value = pick_word();
         index = INDEX_W'($urandom_range(0, 63));
         if (pick < w_push) begin
            mode = MODE_PUSH;
         end else if (pick < w_push + w_pop) begin
            mode = MODE_POP;
         end else if (pick < w_push + w_pop + w_read) begin
            mode = MODE_READ;
            if (stack_fill > 0 && $urandom_range(0, 3) != 0)
               index = INDEX_W'($urandom_range(0, stack_fill - 1));
         end else begin
            mode = MODE_SEARCH;
            if (stack_fill > 0 && $urandom_range(0, 9) < 7)
               value = stack_words[$urandom_range(0, stack_fill - 1)];
         end
         send_request(mode, value, index);
      end
   endtask

   task automatic test_empty_stack();
      send_request(MODE_POP, '1, '0);
      send_request(MODE_READ, '0, '0);
      send_request(MODE_READ, '0, '1);
      send_request(MODE_SEARCH, '0, '0);
   endtask

   task automatic test_push_extremes();
      send_request(MODE_PUSH, '0, '1);
      send_request(MODE_PUSH, '1, '0);
      send_request(MODE_PUSH, 64'h5555_5555_5555_5555, '0);
      send_request(MODE_PUSH, 64'haaaa_aaaa_aaaa_aaaa, '0);
      send_request(MODE_PUSH, '1, '0);
   endtask

   task automatic test_read_positions();
      send_request(MODE_READ, '0, 6'd0);
      send_request(MODE_READ, '0, 6'd4);
      send_request(MODE_READ, '1, 6'd5);
      send_request(MODE_READ, '0, 6'd63);
   endtask

   task automatic test_search_matches();
      send_request(MODE_SEARCH, '1, '0);
      send_request(MODE_SEARCH, 64'haaaa_aaaa_aaaa_aaaa, '0);
      send_request(MODE_SEARCH, 64'h1, '0);
      send_request(MODE_SEARCH, '0, '1);
   endtask

   task automatic test_pop_to_empty();
      repeat (6) send_request(MODE_POP, '0, '0);
   endtask

   task automatic test_fill_and_overflow();
      run_traffic(350, 75, 5, 10);
   endtask

   task automatic test_drain_past_empty();
      run_traffic(350, 10, 70, 10);
   endtask

   task automatic test_mixed_traffic();
      run_traffic(400, 35, 25, 20);
      run_traffic(350, 70, 10, 10);
   endtask

   task automatic test_lookup_heavy();
      run_traffic(300, 15, 10, 35);
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      burst_left  = 0;
      stack_fill  = 0;
      foreach (word_pool[i]) word_pool[i] = {$urandom, $urandom};
      reset     <= 1'b1;
      start     <= 1'b0;
      req_mode  <= MODE_PUSH;
      req_value <= '0;
      req_index <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_push_extremes();
      test_read_positions();
      test_search_matches();
      test_pop_to_empty();
      wait_for_results();
      test_fill_and_overflow();
      wait_for_results();
      test_lookup_heavy();
      test_drain_past_empty();
      wait_for_results();
      test_mixed_traffic();
      wait_for_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** stack_with_index_read_and_search: PASSED **");
      end else begin
         $display("** stack_with_index_read_and_search: FAILED **");
      end
      $finish;
   end

endmodule
